// ===== design/vehicle_antitheft_alarm_controller_core_assert.svh =====
// Assertion macros used by the alarm controller checker
`ifndef VEHICLE_ANTITHEFT_ALARM_CONTROLLER_CORE_ASSERT_SVH
`define VEHICLE_ANTITHEFT_ALARM_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define VAAC_AST_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VAAC_AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vaac_pkg.sv =====
// Types, codes and reset values for the alarm controller
package vaac_pkg;

    typedef enum logic [2:0] {
        MODE_TICK        = 3'd0,
        MODE_ARM         = 3'd1,
        MODE_DISARM      = 3'd2,
        MODE_MECH_DISARM = 3'd3,
        MODE_KEY_CHECK   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_NONE             = 3'd0,
        ST_REFUSED          = 3'd1,
        ST_ALREADY_ARMED    = 3'd2,
        ST_ARMED            = 3'd3,
        ST_DISARMED         = 3'd4,
        ST_ALREADY_DISARMED = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_VIB_HOLD     = 3'd0,
        REG_HORN_PERIOD  = 3'd1,
        REG_RELEASE      = 3'd2,
        REG_LOW_LIMIT    = 3'd3,
        REG_KEY_CONFLICT = 3'd4
    } reg_idx_t;

    localparam int ADDR_W = 5;

    localparam logic [15:0] VIB_HOLD_RST     = 16'd20;
    localparam logic [15:0] HORN_PERIOD_RST  = 16'd800;
    localparam logic [15:0] RELEASE_RST      = 16'd150;
    localparam logic [7:0]  LOW_LIMIT_RST    = 8'd8;
    localparam logic [15:0] KEY_CONFLICT_RST = 16'd30;

    typedef struct packed {
        logic [15:0] vib_hold;
        logic [15:0] horn_period;
        logic [15:0] release_ticks;
        logic [7:0]  low_limit;
        logic [15:0] key_conflict;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       vibration_level;
        logic       wheel_level;
        logic       key_on;
        logic       holdoff_elapsed;
    } item_t;

    typedef struct packed {
        logic        guard_on;
        logic        vib_active;
        logic [15:0] vib_quiet_cnt;
        logic [15:0] horn_timer;
        logic [2:0]  toggle_cnt;
        logic [7:0]  low_run_cnt;
        logic [15:0] high_run_cnt;
        logic        wheel_moved;
        logic        alarm_latched;
        logic        lock_engaged;
        logic        unlock_done;
        logic        mech_key;
        logic [15:0] key_check_cnt;
        logic        wheel_pin;
        logic        elock;
        logic        conflict;
    } state_t;

    localparam state_t STATE_RST = '{
        guard_on:      1'b0,
        vib_active:    1'b0,
        vib_quiet_cnt: 16'd0,
        horn_timer:    16'd0,
        toggle_cnt:    3'd0,
        low_run_cnt:   8'd0,
        high_run_cnt:  16'd0,
        wheel_moved:   1'b0,
        alarm_latched: 1'b0,
        lock_engaged:  1'b0,
        unlock_done:   1'b0,
        mech_key:      1'b0,
        key_check_cnt: 16'd0,
        wheel_pin:     1'b1,
        elock:         1'b0,
        conflict:      1'b0
    };

    typedef struct packed {
        status_t command_status;
        logic    armed;
        logic    horn_pulse;
        logic    wheel_lock_pin;
        logic    electric_lock_drive;
        logic    theft_triggered;
        logic    mechanical_unlocked;
        logic    conflict_warning;
    } result_t;

endpackage

// ===== design/vaac_step.sv =====
// Next-state and result logic for one event word
module vaac_step
(
    input  vaac_pkg::state_t  st,
    input  vaac_pkg::cfg_t    cfg,
    input  vaac_pkg::item_t   item,
    output vaac_pkg::state_t  st_next,
    output vaac_pkg::result_t res
);

    vaac_pkg::state_t  s;
    vaac_pkg::status_t status;
    logic              beep;
    logic              do_arm;
    logic              do_dis;
    logic              mech;

    always_comb
    begin
        s      = st;
        status = vaac_pkg::ST_NONE;
        beep   = 1'b0;
        do_arm = 1'b0;
        do_dis = 1'b0;
        mech   = 1'b0;

        case (item.mode)
            vaac_pkg::MODE_TICK:
            begin
                if (s.guard_on)
                begin
                    if (item.vibration_level)
                    begin
                        s.vib_active    = 1'b1;
                        s.vib_quiet_cnt = 16'd0;
                    end
                    else
                    begin
                        s.vib_quiet_cnt = s.vib_quiet_cnt + 16'd1;
                        if (s.vib_quiet_cnt == cfg.vib_hold)
                        begin
                            s.vib_quiet_cnt = 16'd0;
                            s.vib_active    = 1'b0;
                        end
                    end

                    if (s.vib_active || s.wheel_moved)
                    begin
                        if (item.holdoff_elapsed)
                        begin
                            if (s.horn_timer == 16'd0)
                            begin
                                beep = 1'b1;
                            end
                            else if (s.horn_timer == cfg.horn_period)
                            begin
                                s.horn_timer = 16'd0;
                                beep         = 1'b1;
                            end
                            s.horn_timer = s.horn_timer + 16'd1;
                        end
                    end
                    else
                    begin
                        s.horn_timer = 16'd0;
                    end

                    if (!item.wheel_level)
                    begin
                        s.low_run_cnt = s.low_run_cnt + 8'd1;
                        if (s.toggle_cnt inside {3'd0, 3'd2, 3'd4})
                        begin
                            s.toggle_cnt = s.toggle_cnt + 3'd1;
                        end
                        if (s.toggle_cnt == 3'd5 || s.low_run_cnt > cfg.low_limit)
                        begin
                            s.toggle_cnt  = 3'd0;
                            s.low_run_cnt = 8'd0;
                            if (!s.alarm_latched)
                            begin
                                s.alarm_latched = 1'b1;
                                s.elock         = 1'b1;
                                s.lock_engaged  = 1'b1;
                            end
                            s.wheel_pin    = 1'b0;
                            s.wheel_moved  = 1'b1;
                            s.high_run_cnt = 16'd0;
                        end
                    end
                    else
                    begin
                        if (s.toggle_cnt inside {3'd1, 3'd3})
                        begin
                            s.toggle_cnt = s.toggle_cnt + 3'd1;
                        end
                        s.low_run_cnt  = 8'd0;
                        s.high_run_cnt = s.high_run_cnt + 16'd1;
                        if (s.high_run_cnt == cfg.release_ticks)
                        begin
                            if (s.alarm_latched)
                            begin
                                s.alarm_latched = 1'b0;
                                s.elock         = 1'b0;
                                s.lock_engaged  = 1'b0;
                            end
                            s.wheel_moved  = 1'b0;
                            s.vib_active   = 1'b0;
                            s.high_run_cnt = 16'd0;
                            s.wheel_pin    = 1'b1;
                            s.toggle_cnt   = 3'd0;
                        end
                    end
                end
            end
            vaac_pkg::MODE_ARM:
            begin
                do_arm = 1'b1;
            end
            vaac_pkg::MODE_DISARM:
            begin
                do_dis = 1'b1;
            end
            vaac_pkg::MODE_MECH_DISARM:
            begin
                do_dis = 1'b1;
                mech   = 1'b1;
            end
            vaac_pkg::MODE_KEY_CHECK:
            begin
                if (item.key_on && s.unlock_done)
                begin
                    status = vaac_pkg::ST_NONE;
                end
                else if (item.key_on && s.guard_on && !s.lock_engaged)
                begin
                    s.key_check_cnt = 16'd0;
                    s.mech_key      = 1'b1;
                    do_dis          = 1'b1;
                    mech            = 1'b1;
                end
                else
                begin
                    if (item.key_on && s.guard_on && s.lock_engaged)
                    begin
                        s.key_check_cnt = s.key_check_cnt + 16'd1;
                        if (s.key_check_cnt == cfg.key_conflict)
                        begin
                            s.key_check_cnt = 16'd0;
                            s.conflict      = 1'b1;
                        end
                    end
                    if (!item.key_on && s.mech_key)
                    begin
                        s.mech_key = 1'b0;
                        do_arm     = 1'b1;
                    end
                end
            end
            default:
            begin
                status = vaac_pkg::ST_NONE;
            end
        endcase

        if (do_arm)
        begin
            if (item.key_on)
            begin
                status = vaac_pkg::ST_REFUSED;
            end
            else if (s.guard_on)
            begin
                status = vaac_pkg::ST_ALREADY_ARMED;
            end
            else
            begin
                s.unlock_done = 1'b0;
                s.guard_on    = 1'b1;
                status        = vaac_pkg::ST_ARMED;
            end
        end

        if (do_dis)
        begin
            s.unlock_done = 1'b1;
            if (!mech)
            begin
                s.elock = 1'b1;
            end
            if (!s.guard_on)
            begin
                status = vaac_pkg::ST_ALREADY_DISARMED;
            end
            else
            begin
                s.wheel_pin     = 1'b1;
                s.guard_on      = 1'b0;
                s.vib_active    = 1'b0;
                s.vib_quiet_cnt = 16'd0;
                s.horn_timer    = 16'd0;
                s.toggle_cnt    = 3'd0;
                s.low_run_cnt   = 8'd0;
                s.high_run_cnt  = 16'd0;
                s.wheel_moved   = 1'b0;
                s.alarm_latched = 1'b0;
                if (!mech)
                begin
                    s.lock_engaged = 1'b0;
                end
                status = vaac_pkg::ST_DISARMED;
            end
        end

        st_next                 = s;
        res.command_status      = status;
        res.armed               = s.guard_on;
        res.horn_pulse          = beep;
        res.wheel_lock_pin      = s.wheel_pin;
        res.electric_lock_drive = s.elock;
        res.theft_triggered     = s.alarm_latched;
        res.mechanical_unlocked = s.mech_key;
        res.conflict_warning    = s.conflict;
    end

endmodule

// ===== design/vehicle_antitheft_alarm_controller_core.sv =====
// Top level of the two-wheeler anti-theft alarm controller
// One event word is taken per clock while results are taken: the word lands in an
// input register, the controller state and the result are computed from it by the
// step logic, and the result sits in an output register until taken. A result is
// valid once its word has passed the input register and then the output register,
// and the sustained rate is one word per cycle while result_ready is high. The five
// tuning registers are written and read over the APB port at byte offsets 0x00-0x10.
module vehicle_antitheft_alarm_controller_core
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vaac_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [2:0]                  mode,
    input  logic                        vibration_level,
    input  logic                        wheel_level,
    input  logic                        key_on,
    input  logic                        holdoff_elapsed,

    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [2:0]                  command_status,
    output logic                        armed,
    output logic                        horn_pulse,
    output logic                        wheel_lock_pin,
    output logic                        electric_lock_drive,
    output logic                        theft_triggered,
    output logic                        mechanical_unlocked,
    output logic                        conflict_warning
);

    vaac_pkg::cfg_t    cfg_reg;
    vaac_pkg::state_t  state_reg;
    vaac_pkg::state_t  state_next;
    vaac_pkg::item_t   item_reg;
    logic              item_valid_reg;
    vaac_pkg::result_t res_reg;
    vaac_pkg::result_t res_next;
    logic              res_valid_reg;
    logic              advance;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vib_hold      <= vaac_pkg::VIB_HOLD_RST;
            cfg_reg.horn_period   <= vaac_pkg::HORN_PERIOD_RST;
            cfg_reg.release_ticks <= vaac_pkg::RELEASE_RST;
            cfg_reg.low_limit     <= vaac_pkg::LOW_LIMIT_RST;
            cfg_reg.key_conflict  <= vaac_pkg::KEY_CONFLICT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                vaac_pkg::REG_VIB_HOLD:     cfg_reg.vib_hold      <= pwdata[15:0];
                vaac_pkg::REG_HORN_PERIOD:  cfg_reg.horn_period   <= pwdata[15:0];
                vaac_pkg::REG_RELEASE:      cfg_reg.release_ticks <= pwdata[15:0];
                vaac_pkg::REG_LOW_LIMIT:    cfg_reg.low_limit     <= pwdata[7:0];
                vaac_pkg::REG_KEY_CONFLICT: cfg_reg.key_conflict  <= pwdata[15:0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            vaac_pkg::REG_VIB_HOLD:     prdata = {16'd0, cfg_reg.vib_hold};
            vaac_pkg::REG_HORN_PERIOD:  prdata = {16'd0, cfg_reg.horn_period};
            vaac_pkg::REG_RELEASE:      prdata = {16'd0, cfg_reg.release_ticks};
            vaac_pkg::REG_LOW_LIMIT:    prdata = {24'd0, cfg_reg.low_limit};
            vaac_pkg::REG_KEY_CONFLICT: prdata = {16'd0, cfg_reg.key_conflict};
            default:                    prdata = 32'd0;
        endcase
    end

    assign advance    = item_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.mode            <= mode;
            item_reg.vibration_level <= vibration_level;
            item_reg.wheel_level     <= wheel_level;
            item_reg.key_on          <= key_on;
            item_reg.holdoff_elapsed <= holdoff_elapsed;
        end
    end

    vaac_step u_step
    (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vaac_pkg::STATE_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid        = res_valid_reg;
    assign command_status      = res_reg.command_status;
    assign armed               = res_reg.armed;
    assign horn_pulse          = res_reg.horn_pulse;
    assign wheel_lock_pin      = res_reg.wheel_lock_pin;
    assign electric_lock_drive = res_reg.electric_lock_drive;
    assign theft_triggered     = res_reg.theft_triggered;
    assign mechanical_unlocked = res_reg.mechanical_unlocked;
    assign conflict_warning    = res_reg.conflict_warning;

endmodule

// ===== design/vaac_checker.sv =====
// Port-level checker for the alarm controller and its bind
`include "vehicle_antitheft_alarm_controller_core_assert.svh"

module vaac_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] command_status,
    input logic       armed,
    input logic       horn_pulse,
    input logic       theft_triggered
);

    `VAAC_AST_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(command_status) && $stable(armed), "result word changed while stalled")
    `VAAC_AST_SAME(a_horn_needs_guard, result_valid && !armed, !horn_pulse, "horn pulse while disarmed")
    `VAAC_AST_SAME(a_theft_needs_guard, result_valid && !armed, !theft_triggered, "theft latched while disarmed")
    `VAAC_AST_SAME(a_armed_status, result_valid && command_status == vaac_pkg::ST_ARMED, armed, "armed status without guard")
    `VAAC_AST_SAME(a_disarmed_status, result_valid && command_status == vaac_pkg::ST_DISARMED, !armed && !theft_triggered, "disarmed status with guard")

endmodule

bind vehicle_antitheft_alarm_controller_core vaac_checker u_vaac_checker (.*);

// ===== test/vehicle_antitheft_alarm_controller_core_tb.sv =====
// Self-checking testbench for the two-wheeler anti-theft alarm controller
module vehicle_antitheft_alarm_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [vaac_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          item_valid = 1'b0;
    logic                          item_ready;
    logic [2:0]                    mode = '0;
    logic                          vibration_level = 1'b0;
    logic                          wheel_level = 1'b1;
    logic                          key_on = 1'b0;
    logic                          holdoff_elapsed = 1'b0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic [2:0]                    command_status;
    logic                          armed;
    logic                          horn_pulse;
    logic                          wheel_lock_pin;
    logic                          electric_lock_drive;
    logic                          theft_triggered;
    logic                          mechanical_unlocked;
    logic                          conflict_warning;

    vehicle_antitheft_alarm_controller_core uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .item_valid          (item_valid),
        .item_ready          (item_ready),
        .mode                (mode),
        .vibration_level     (vibration_level),
        .wheel_level         (wheel_level),
        .key_on              (key_on),
        .holdoff_elapsed     (holdoff_elapsed),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .command_status      (command_status),
        .armed               (armed),
        .horn_pulse          (horn_pulse),
        .wheel_lock_pin      (wheel_lock_pin),
        .electric_lock_drive (electric_lock_drive),
        .theft_triggered     (theft_triggered),
        .mechanical_unlocked (mechanical_unlocked),
        .conflict_warning    (conflict_warning)
    );

    // predicted controller configuration and state
    logic [15:0] hold_ticks = vaac_pkg::VIB_HOLD_RST;
    logic [15:0] horn_period = vaac_pkg::HORN_PERIOD_RST;
    logic [15:0] release_len = vaac_pkg::RELEASE_RST;
    logic [7:0]  low_limit = vaac_pkg::LOW_LIMIT_RST;
    logic [15:0] conflict_len = vaac_pkg::KEY_CONFLICT_RST;

    logic        guard = 1'b0;
    logic        vib_busy = 1'b0;
    logic [15:0] quiet_run = '0;
    logic [15:0] horn_run = '0;
    logic [2:0]  edge_steps = '0;
    logic [7:0]  low_run = '0;
    logic [15:0] high_run = '0;
    logic        wheel_moving = 1'b0;
    logic        theft_latch = 1'b0;
    logic        lock_held = 1'b0;
    logic        unlocked = 1'b0;
    logic        mech_rearm = 1'b0;
    logic [15:0] key_run = '0;
    logic        lock_pin = 1'b1;
    logic        elock = 1'b0;
    logic        conflict = 1'b0;

    vaac_pkg::item_t   event_words[$];
    vaac_pkg::result_t due_results[$];
    vaac_pkg::item_t   word_now;
    int                send_gap = 0;
    int                recv_gap = 0;
    bit                idle_on = 1'b0;
    int                stall_cycles = 0;
    int                errors = 0;

    function automatic vaac_pkg::item_t ev(logic [2:0] m, logic vib, logic whl, logic key,
                                           logic hold);
        vaac_pkg::item_t w;
        w.mode = m;
        w.vibration_level = vib;
        w.wheel_level = whl;
        w.key_on = key;
        w.holdoff_elapsed = hold;
        return w;
    endfunction

    function automatic vaac_pkg::status_t arm_request(logic key);
        if (key)
            return vaac_pkg::ST_REFUSED;
        if (guard)
            return vaac_pkg::ST_ALREADY_ARMED;
        unlocked = 1'b0;
        guard = 1'b1;
        return vaac_pkg::ST_ARMED;
    endfunction

    function automatic vaac_pkg::status_t disarm_request(logic mech);
        unlocked = 1'b1;
        if (!mech)
            elock = 1'b1;
        if (!guard)
            return vaac_pkg::ST_ALREADY_DISARMED;
        lock_pin = 1'b1;
        guard = 1'b0;
        vib_busy = 1'b0;
        quiet_run = '0;
        horn_run = '0;
        edge_steps = '0;
        low_run = '0;
        high_run = '0;
        wheel_moving = 1'b0;
        theft_latch = 1'b0;
        if (!mech)
            lock_held = 1'b0;
        return vaac_pkg::ST_DISARMED;
    endfunction

    function automatic logic tick_update(logic vib, logic whl, logic hold);
        logic beep;
        beep = 1'b0;
        if (!guard)
            return 1'b0;
        if (vib)
        begin
            vib_busy = 1'b1;
            quiet_run = '0;
        end
        else
        begin
            quiet_run = quiet_run + 16'd1;
            if (quiet_run == hold_ticks)
            begin
                quiet_run = '0;
                vib_busy = 1'b0;
            end
        end
        if (vib_busy || wheel_moving)
        begin
            if (hold)
            begin
                if (horn_run == 16'd0)
                begin
                    beep = 1'b1;
                end
                else if (horn_run == horn_period)
                begin
                    horn_run = '0;
                    beep = 1'b1;
                end
                horn_run = horn_run + 16'd1;
            end
        end
        else
        begin
            horn_run = '0;
        end
        if (!whl)
        begin
            low_run = low_run + 8'd1;
            if (edge_steps == 3'd0 || edge_steps == 3'd2 || edge_steps == 3'd4)
                edge_steps = edge_steps + 3'd1;
            if (edge_steps == 3'd5 || low_run > low_limit)
            begin
                edge_steps = '0;
                low_run = '0;
                if (!theft_latch)
                begin
                    theft_latch = 1'b1;
                    elock = 1'b1;
                    lock_held = 1'b1;
                end
                lock_pin = 1'b0;
                wheel_moving = 1'b1;
                high_run = '0;
            end
        end
        else
        begin
            if (edge_steps == 3'd1 || edge_steps == 3'd3)
                edge_steps = edge_steps + 3'd1;
            low_run = '0;
            high_run = high_run + 16'd1;
            if (high_run == release_len)
            begin
                if (theft_latch)
                begin
                    theft_latch = 1'b0;
                    elock = 1'b0;
                    lock_held = 1'b0;
                end
                wheel_moving = 1'b0;
                vib_busy = 1'b0;
                high_run = '0;
                lock_pin = 1'b1;
                edge_steps = '0;
            end
        end
        return beep;
    endfunction

    function automatic vaac_pkg::status_t key_check(logic key);
        if (key && unlocked)
            return vaac_pkg::ST_NONE;
        if (key && guard && !lock_held)
        begin
            key_run = '0;
            mech_rearm = 1'b1;
            return disarm_request(1'b1);
        end
        if (key && guard && lock_held)
        begin
            key_run = key_run + 16'd1;
            if (key_run == conflict_len)
            begin
                key_run = '0;
                conflict = 1'b1;
            end
        end
        if (!key && mech_rearm)
        begin
            mech_rearm = 1'b0;
            return arm_request(1'b0);
        end
        return vaac_pkg::ST_NONE;
    endfunction

    function automatic vaac_pkg::result_t alarm_step(vaac_pkg::item_t w);
        vaac_pkg::result_t r;
        vaac_pkg::status_t st;
        logic              beep;
        st = vaac_pkg::ST_NONE;
        beep = 1'b0;
        case (w.mode)
            vaac_pkg::MODE_TICK:        beep = tick_update(w.vibration_level, w.wheel_level,
                                                           w.holdoff_elapsed);
            vaac_pkg::MODE_ARM:         st = arm_request(w.key_on);
            vaac_pkg::MODE_DISARM:      st = disarm_request(1'b0);
            vaac_pkg::MODE_MECH_DISARM: st = disarm_request(1'b1);
            vaac_pkg::MODE_KEY_CHECK:   st = key_check(w.key_on);
            default:                    ;
        endcase
        r.command_status = st;
        r.armed = guard;
        r.horn_pulse = beep;
        r.wheel_lock_pin = lock_pin;
        r.electric_lock_drive = elock;
        r.theft_triggered = theft_latch;
        r.mechanical_unlocked = mech_rearm;
        r.conflict_warning = conflict;
        return r;
    endfunction

    function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver: present queued words, log a prediction on every accepted word
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (item_valid && item_ready)
                due_results.push_back(alarm_step(word_now));
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 9);
                    item_valid <= 1'b0;
                end
                else if (event_words.size() != 0)
                begin
                    word_now = event_words.pop_front();
                    item_valid <= 1'b1;
                    mode <= word_now.mode;
                    vibration_level <= word_now.vibration_level;
                    wheel_level <= word_now.wheel_level;
                    key_on <= word_now.key_on;
                    holdoff_elapsed <= word_now.holdoff_elapsed;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        vaac_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, command_status);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("command_status", want.command_status, command_status);
                    check_field("armed", {2'b00, want.armed}, {2'b00, armed});
                    check_field("horn_pulse", {2'b00, want.horn_pulse}, {2'b00, horn_pulse});
                    check_field("wheel_lock_pin", {2'b00, want.wheel_lock_pin},
                                {2'b00, wheel_lock_pin});
                    check_field("electric_lock_drive", {2'b00, want.electric_lock_drive},
                                {2'b00, electric_lock_drive});
                    check_field("theft_triggered", {2'b00, want.theft_triggered},
                                {2'b00, theft_triggered});
                    check_field("mechanical_unlocked", {2'b00, want.mechanical_unlocked},
                                {2'b00, mechanical_unlocked});
                    check_field("conflict_warning", {2'b00, want.conflict_warning},
                                {2'b00, conflict_warning});
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic reg_write(vaac_pkg::reg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            vaac_pkg::REG_VIB_HOLD:     hold_ticks = val;
            vaac_pkg::REG_HORN_PERIOD:  horn_period = val;
            vaac_pkg::REG_RELEASE:      release_len = val;
            vaac_pkg::REG_LOW_LIMIT:    low_limit = val[7:0];
            vaac_pkg::REG_KEY_CONFLICT: conflict_len = val;
            default:                    ;
        endcase
    endtask

    task automatic set_config(int vib_hold, int horn, int rel, int low, int keys);
        reg_write(vaac_pkg::REG_VIB_HOLD, 16'(vib_hold));
        reg_write(vaac_pkg::REG_HORN_PERIOD, 16'(horn));
        reg_write(vaac_pkg::REG_RELEASE, 16'(rel));
        reg_write(vaac_pkg::REG_LOW_LIMIT, 16'(low));
        reg_write(vaac_pkg::REG_KEY_CONFLICT, 16'(keys));
    endtask

    task automatic set_small_config();
        set_config($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(1, 14),
                   $urandom_range(0, 6), $urandom_range(1, 5));
    endtask

    task automatic drain();
        while (event_words.size() != 0 || item_valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_random_words(int count);
        int         done;
        int         n;
        int         pat;
        int         k;
        logic [2:0] m;
        logic       w;
        done = 0;
        while (done < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(4, 30);
                    pat = $urandom_range(0, 3);
                    event_words.push_back(ev(vaac_pkg::MODE_ARM, 1'($urandom), 1'($urandom),
                                             1'b0, 1'($urandom)));
                    for (k = 0; k < n; k++)
                    begin
                        case (pat)
                            0:       w = k[0];
                            1:       w = ($urandom_range(0, 7) == 0);
                            2:       w = ($urandom_range(0, 7) != 0);
                            default: w = 1'($urandom);
                        endcase
                        event_words.push_back(ev(vaac_pkg::MODE_TICK,
                                                 $urandom_range(0, 3) == 0, w,
                                                 1'($urandom), $urandom_range(0, 3) != 0));
                    end
                    done += n + 1;
                end
                4, 5:
                begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'($urandom),
                                                     1'($urandom), 1'($urandom),
                                                     1'($urandom)));
                        event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'($urandom),
                                                 1'($urandom), 1'b1, 1'($urandom)));
                    end
                    event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'($urandom),
                                             1'($urandom), 1'b0, 1'($urandom)));
                    done += n + 1;
                end
                6, 7:
                begin
                    m = 3'($urandom_range(vaac_pkg::MODE_ARM, vaac_pkg::MODE_MECH_DISARM));
                    event_words.push_back(ev(m, 1'($urandom), 1'($urandom), 1'($urandom),
                                             1'($urandom)));
                    done++;
                end
                8:
                begin
                    m = 3'($urandom_range(0, 7));
                    event_words.push_back(ev(m, 1'($urandom), 1'($urandom), 1'($urandom),
                                             1'($urandom)));
                    if (m <= vaac_pkg::MODE_KEY_CHECK)
                        done++;
                end
                default:
                begin
                    n = $urandom_range(1, 20);
                    for (k = 0; k < n; k++)
                        event_words.push_back(ev(vaac_pkg::MODE_TICK,
                                                 $urandom_range(0, 3) == 0, 1'b1,
                                                 1'($urandom), 1'b1));
                    done += n;
                end
            endcase
        end
    endtask

    initial
    begin
        logic [2:0] m;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset configuration
        event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'b1, 1'b0, 1'b1, 1'b1));
        event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_DISARM, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_MECH_DISARM, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_ARM, 1'b0, 1'b1, 1'b1, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_ARM, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_ARM, 1'b0, 1'b1, 1'b0, 1'b0));
        for (m = vaac_pkg::MODE_KEY_CHECK + 3'd1; m != 3'd0; m++)
            event_words.push_back(ev(m, 1'b1, 1'b0, 1'b1, 1'b1));
        event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'b1, 1'b0, 1'b0, 1'b1));
        event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'b0, 1'b1, 1'b0, 1'b1));
        event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
        event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_TICK, 1'b0, 1'b0, 1'b0, 1'b1));
        event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'b0, 1'b1, 1'b1, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_DISARM, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_ARM, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'b0, 1'b1, 1'b1, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'b0, 1'b1, 1'b1, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_KEY_CHECK, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_MECH_DISARM, 1'b0, 1'b1, 1'b0, 1'b0));
        event_words.push_back(ev(vaac_pkg::MODE_ARM, 1'b0, 1'b1, 1'b0, 1'b0));
        drain();

        idle_on = 1'b1;
        set_small_config();
        add_random_words(300);
        drain();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_random_words(150);
        drain();

        set_config(1, 1, 1, 0, 1);
        add_random_words(200);
        drain();

        repeat (3)
        begin
            set_small_config();
            add_random_words(250);
            drain();
        end

        idle_on = 1'b0;
        set_small_config();
        add_random_words(250);
        drain();

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/vaac_pkg.sv
design/vaac_step.sv
design/vehicle_antitheft_alarm_controller_core.sv
design/vaac_checker.sv
test/vehicle_antitheft_alarm_controller_core_tb.sv
